@@ rtl/gic_pkg.sv @@
// shared constants, types and register map for the gpio interrupt controller
package gic_pkg;

  // number of interrupt lines implemented (1 to 32)
  localparam int unsigned LINES = 32;

  localparam logic [32:0] LINE_ONE_SHIFT = 33'd1 << LINES;
  localparam logic [31:0] LINE_MASK      = 32'(LINE_ONE_SHIFT - 33'd1);
  localparam logic [5:0]  LINES_COUNT    = 6'(LINES);

  // item commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // register map, word offsets
  localparam logic [4:0] REG_DATA = 5'd0;
  localparam logic [4:0] REG_DIR  = 5'd1;
  localparam logic [4:0] REG_EN   = 5'd12;
  localparam logic [4:0] REG_MASK = 5'd13;
  localparam logic [4:0] REG_TYPE = 5'd14;
  localparam logic [4:0] REG_POL  = 5'd15;
  localparam logic [4:0] REG_STAT = 5'd16;
  localparam logic [4:0] REG_RAW  = 5'd17;
  localparam logic [4:0] REG_DEB  = 5'd18;
  localparam logic [4:0] REG_EOI  = 5'd19;
  localparam logic [4:0] REG_EXT  = 5'd20;
  localparam logic [4:0] REG_SYNC = 5'd24;

  // one bus access or pin sample
  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } gic_item_t;

  // pending line summary
  typedef struct packed {
    logic       irq;
    logic [4:0] first;
    logic       valid;
  } gic_pend_t;

endpackage

@@ rtl/gpio_interrupt_controller_unit.sv @@
// top level of the gpio interrupt controller: input register, logic, result register
//
//   port group | direction | handshake         | payload
//   in_        | input     | in_valid/in_stall | cmd, reg_index, write_data, pin_levels
//   out_       | output    | out_valid/out_stall | read_data, irq_out, first_pending,
//              |           |                   | pending_valid
//   cfg_       | input     | cfg_valid/cfg_ready | line_count
//
// an item passes through the input register and then the result register;
// one item per cycle sustained while out_stall is low, set by the single state update.
// rst_n is synchronous; valid flags and state registers clear (payload registers do not) and line count returns to 32.
// out_stall holds the result register and, once both registers are full, raises in_stall.
// cfg_ready is always high.
module gpio_interrupt_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_out,
  output logic [4:0]  out_first_pending,
  output logic        out_pending_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_line_count
);
  import gic_pkg::*;

  logic       in_vld_r, out_vld_r;
  gic_item_t  item_r;
  logic [5:0] line_count_r;
  logic       advance, in_xfer;
  logic [31:0] rd, status_nxt;
  gic_pend_t  pend;
  logic [31:0] rd_r;
  gic_pend_t  pend_r;

  // handshake control
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= '{cmd: in_cmd, reg_index: in_reg_index,
                  write_data: in_write_data, pin_levels: in_pin_levels};
    end
  end

  // line count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= LINES_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      line_count_r <= cfg_line_count;
    end
  end

  gic_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (advance),
    .item       (item_r),
    .read_data  (rd),
    .status_nxt (status_nxt)
  );

  gic_prio u_prio (
    .status     (status_nxt),
    .line_count (line_count_r),
    .pend       (pend)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_r   <= rd;
      pend_r <= pend;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = rd_r;
  assign out_irq_out       = pend_r.irq;
  assign out_first_pending = pend_r.first;
  assign out_pending_valid = pend_r.valid;

endmodule

@@ rtl/gic_regs.sv @@
// register file, pin sampling and edge latches of the gpio interrupt controller
module gic_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_fire,
  input  gic_pkg::gic_item_t item,
  output logic [31:0]       read_data,
  output logic [31:0]       status_nxt
);
  import gic_pkg::*;

  logic [31:0] data_r, dir_r, en_r, mask_r, type_r, pol_r, latch_r, pins_r, deb_r;
  logic        sync_r;
  logic [31:0] data_nxt, dir_nxt, en_nxt, mask_nxt, type_nxt, pol_nxt;
  logic [31:0] latch_nxt, pins_nxt, deb_nxt;
  logic        sync_nxt;
  logic [31:0] wmask, pins_m, rise, fall, hit;
  logic [31:0] raw_cur, stat_cur, raw_nxt;
  logic        is_write;

  // status of the current state, used by reads
  assign raw_cur  = ((type_r & latch_r) | (~type_r & ~(pins_r ^ pol_r))) & LINE_MASK;
  assign stat_cur = raw_cur & en_r & ~mask_r;

  // edge detection against the previous sample
  assign pins_m = item.pin_levels & LINE_MASK;
  assign rise   = pins_m & ~pins_r;
  assign fall   = ~pins_m & pins_r;
  assign hit    = (pol_r & rise) | (~pol_r & fall);
  assign wmask  = item.write_data & LINE_MASK;
  assign is_write = item_fire && (item.cmd == CMD_WRITE);

  // next state for the item
  always_comb begin
    data_nxt  = data_r;
    dir_nxt   = dir_r;
    en_nxt    = en_r;
    mask_nxt  = mask_r;
    type_nxt  = type_r;
    pol_nxt   = pol_r;
    latch_nxt = latch_r;
    pins_nxt  = pins_r;
    deb_nxt   = deb_r;
    sync_nxt  = sync_r;
    if (is_write) begin
      unique case (item.reg_index)
        REG_DATA: data_nxt  = wmask;
        REG_DIR:  dir_nxt   = wmask;
        REG_EN:   en_nxt    = wmask;
        REG_MASK: mask_nxt  = wmask;
        REG_TYPE: type_nxt  = wmask;
        REG_POL:  pol_nxt   = wmask;
        REG_DEB:  deb_nxt   = wmask;
        REG_EOI:  latch_nxt = latch_r & ~wmask;
        REG_SYNC: sync_nxt  = item.write_data[0];
        default: ;
      endcase
    end else if (item_fire && (item.cmd == CMD_TICK)) begin
      latch_nxt = (latch_r | (hit & type_r)) & LINE_MASK;
      pins_nxt  = pins_m;
    end
  end

  // status after the item
  assign raw_nxt    = ((type_nxt & latch_nxt) | (~type_nxt & ~(pins_nxt ^ pol_nxt)))
                      & LINE_MASK;
  assign status_nxt = raw_nxt & en_nxt & ~mask_nxt;

  // register read decode
  always_comb begin
    read_data = 32'd0;
    if (item.cmd == CMD_READ) begin
      unique case (item.reg_index)
        REG_DATA: read_data = data_r;
        REG_DIR:  read_data = dir_r;
        REG_EN:   read_data = en_r;
        REG_MASK: read_data = mask_r;
        REG_TYPE: read_data = type_r;
        REG_POL:  read_data = pol_r;
        REG_STAT: read_data = stat_cur;
        REG_RAW:  read_data = raw_cur;
        REG_DEB:  read_data = deb_r;
        REG_EXT:  read_data = pins_r;
        REG_SYNC: read_data = {31'd0, sync_r};
        default:  read_data = 32'd0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r  <= '0;
      dir_r   <= '0;
      en_r    <= '0;
      mask_r  <= '0;
      type_r  <= '0;
      pol_r   <= '0;
      latch_r <= '0;
      pins_r  <= '0;
      deb_r   <= '0;
      sync_r  <= 1'b0;
    end else begin
      data_r  <= data_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
      mask_r  <= mask_nxt;
      type_r  <= type_nxt;
      pol_r   <= pol_nxt;
      latch_r <= latch_nxt;
      pins_r  <= pins_nxt;
      deb_r   <= deb_nxt;
      sync_r  <= sync_nxt;
    end
  end

endmodule

@@ rtl/gic_prio.sv @@
// lowest pending line encoder with line count limit
module gic_prio (
  input  logic [31:0]        status,
  input  logic [5:0]         line_count,
  output gic_pkg::gic_pend_t pend
);
  import gic_pkg::*;

  logic [31:0] lowest;
  logic [4:0]  idx;
  logic [5:0]  cnt;

  // isolate the lowest set bit
  assign lowest = status & (~status + 32'd1);

  // encode the one-hot position, one index bit at a time
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      idx[k] = 1'b0;
      for (int b = 0; b < 32; b++) begin
        if (((b >> k) & 1) == 1) idx[k] = idx[k] | lowest[b];
      end
    end
  end

  // saturate the configured count
  assign cnt = (line_count > LINES_COUNT) ? LINES_COUNT : line_count;

  always_comb begin
    pend.irq   = |status;
    pend.valid = pend.irq && ({1'b0, idx} < cnt);
    pend.first = pend.valid ? idx : 5'd0;
  end

endmodule
